/* hw/rtl/bb3_pkg.sv */
// shared types and constants of the 3x3 rgb box blur
package bb3_pkg;

    localparam int PIX_W        = 8;
    localparam int RGB_W        = 3 * PIX_W;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 13'd768;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef logic [RGB_W-1:0] t_rgb;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] in_red;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             frame_last;
    } t_out_item;

endpackage

/* hw/rtl/box_blur_3x3_rgb.sv */
// 3x3 box blur over an rgb raster stream with two line memories and a window
// a result passes the stage 1, window, column sum, total sum and output registers in that order
// throughput: one item per clock while the output is not stalled, one read and one write per line memory per item
// a result trails its pixel by image_width+1 items; image_width+1 drain items end a frame
// reset: position counters clear, size registers return to 1024 x 768
// line memories are not cleared; never-written entries fall outside the image only
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  bb3_pkg::t_in_item                   i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output bb3_pkg::t_out_item                  o_out,
    input  logic                                i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bb3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int CSUM_W = PIX_W + 2;
    localparam int TSUM_W = PIX_W + 4;
    localparam int MUL_W  = 13;
    localparam int SHF_W  = 5;
    localparam int PROD_W = TSUM_W + MUL_W;

    localparam logic [MUL_W-1:0] RECIP_ONE   = 13'd1;
    localparam logic [MUL_W-1:0] RECIP_THREE = 13'd2731;
    localparam logic [MUL_W-1:0] RECIP_NINE  = 13'd7282;

    typedef struct packed {
        logic top_out;
        logic bot_out;
        logic left_out;
        logic right_out;
        logic last;
    } t_pos;

    logic [WIDTH_REG_W-1:0]  r_image_width;
    logic [HEIGHT_REG_W-1:0] r_image_height;
    logic [WID_W-1:0]        eff_w;
    logic [HGT_W-1:0]        eff_h;
    logic [ROW_W-1:0]        row_h;

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic in_xfer, in_load, draining, col_zero, col_end;
    logic s0_res;
    t_pos s0_pos;
    t_rgb s0_fresh;

    t_rgb r_upper_line [MAX_WIDTH];
    t_rgb r_lower_line [MAX_WIDTH];
    t_rgb r_rd_top, r_rd_mid, r_fwd_top, r_fwd_mid;
    logic r_fwd;

    logic             r_v1, r_s1_res;
    t_pos             r_s1_pos;
    logic [COL_W-1:0] r_s1_addr;
    t_rgb             r_s1_fresh;
    t_rgb             s1_top, s1_mid;

    t_rgb r_win [3][3];
    logic r_v2;
    t_pos r_s2_pos;

    logic              r_v3;
    t_pos              r_s3_pos;
    logic [CSUM_W-1:0] r_s3_col [3][3];
    logic [CSUM_W-1:0] s2_col [3][3];

    logic              r_v4;
    logic [TSUM_W-1:0] r_s4_sum [3];
    logic [MUL_W-1:0]  r_s4_mul;
    logic [SHF_W-1:0]  r_s4_shf;
    logic              r_s4_last;
    logic [TSUM_W-1:0] s3_sum [3];
    logic [1:0]        s3_rows, s3_cols;
    logic [3:0]        s3_cnt;
    logic [MUL_W-1:0]  s3_mul;
    logic [SHF_W-1:0]  s3_shf;

    logic             r_ov;
    t_out_item        r_out;
    logic [PIX_W-1:0] s4_q [3];

    logic out_free, s4_free, s3_free, s2_free, s1_free, s1_exit;

    // size limits
    always_comb begin
        priority if (r_image_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(r_image_width);
        end
        priority if (r_image_height == '0) begin
            eff_h = HGT_W'(1);
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HGT_W'(r_image_height);
        end
    end

    assign row_h = ROW_W'(eff_h);

    // handshake chain
    assign out_free   = !r_ov || i_out_ready;
    assign s4_free    = !r_v4 || out_free;
    assign s3_free    = !r_v3 || s4_free;
    assign s2_free    = !r_v2 || s3_free;
    assign s1_exit    = r_v1 && s2_free;
    assign s1_free    = !r_v1 || s2_free;
    assign o_in_ready = s1_free;

    // input position and result position
    assign in_xfer  = i_in_valid && o_in_ready;
    assign draining = r_row >= row_h;
    assign in_load  = in_xfer && !(i_in.kind == KIND_DRAIN && !draining);
    assign col_zero = r_col == '0;
    assign col_end  = (WID_W'(r_col) + WID_W'(1)) == eff_w;
    assign s0_fresh = draining ? '0 : {i_in.in_red, i_in.in_green, i_in.in_blue};

    always_comb begin
        if (!col_zero) begin
            s0_res           = (r_row >= ROW_W'(1)) && (r_row <= row_h);
            s0_pos.top_out   = r_row == ROW_W'(1);
            s0_pos.bot_out   = r_row == row_h;
            s0_pos.left_out  = r_col == COL_W'(1);
            s0_pos.right_out = 1'b0;
            s0_pos.last      = 1'b0;
        end else begin
            s0_res           = (r_row >= ROW_W'(2)) && (r_row <= row_h + ROW_W'(1));
            s0_pos.top_out   = r_row == ROW_W'(2);
            s0_pos.bot_out   = r_row == row_h + ROW_W'(1);
            s0_pos.left_out  = eff_w == WID_W'(1);
            s0_pos.right_out = 1'b1;
            s0_pos.last      = r_row == row_h + ROW_W'(1);
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (in_load) begin
            priority if (s0_pos.last) begin
                n_col = '0;
                n_row = '0;
            end else if (col_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_v3           <= 1'b0;
            r_v4           <= 1'b0;
            r_ov           <= 1'b0;
            r_fwd          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (s1_free) begin
                r_v1 <= in_load;
            end
            if (s2_free) begin
                r_v2 <= s1_exit && r_s1_res;
            end
            if (s3_free) begin
                r_v3 <= r_v2;
            end
            if (s4_free) begin
                r_v4 <= r_v3;
            end
            if (out_free) begin
                r_ov <= r_v4;
            end
            if (in_load) begin
                r_fwd <= r_v1 && (r_s1_addr == r_col);
            end
        end
    end

    // line memories: read when an input item is loaded, write back when the item leaves stage 1
    always_ff @(posedge i_clk) begin
        if (s1_exit) begin
            r_upper_line[r_s1_addr] <= s1_mid;
        end
        if (in_load) begin
            r_rd_top <= r_upper_line[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_exit) begin
            r_lower_line[r_s1_addr] <= r_s1_fresh;
        end
        if (in_load) begin
            r_rd_mid <= r_lower_line[r_col];
        end
    end

    // same-address forwarding when the width is one pixel
    assign s1_top = r_fwd ? r_fwd_top : r_rd_top;
    assign s1_mid = r_fwd ? r_fwd_mid : r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_fwd_top  <= s1_mid;
            r_fwd_mid  <= r_s1_fresh;
            r_s1_res   <= s0_res;
            r_s1_pos   <= s0_pos;
            r_s1_addr  <= r_col;
            r_s1_fresh <= s0_fresh;
        end
    end

    // window shift
    always_ff @(posedge i_clk) begin
        if (s1_exit) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= s1_top;
            r_win[1][2] <= s1_mid;
            r_win[2][2] <= r_s1_fresh;
            r_s2_pos    <= r_s1_pos;
        end
    end

    // column sums with row masking
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int j = 0; j < 3; j++) begin
                s2_col[ch][j] =
                    (r_s2_pos.top_out ? '0 : CSUM_W'(r_win[0][j][RGB_W-1-PIX_W*ch -: PIX_W]))
                    + CSUM_W'(r_win[1][j][RGB_W-1-PIX_W*ch -: PIX_W])
                    + (r_s2_pos.bot_out ? '0 : CSUM_W'(r_win[2][j][RGB_W-1-PIX_W*ch -: PIX_W]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_free) begin
            r_s3_col <= s2_col;
            r_s3_pos <= r_s2_pos;
        end
    end

    // total sum and reciprocal select
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s3_sum[ch] = (r_s3_pos.left_out ? '0 : TSUM_W'(r_s3_col[ch][0]))
                       + TSUM_W'(r_s3_col[ch][1])
                       + (r_s3_pos.right_out ? '0 : TSUM_W'(r_s3_col[ch][2]));
        end
        s3_rows = 2'd3 - 2'(r_s3_pos.top_out) - 2'(r_s3_pos.bot_out);
        s3_cols = 2'd3 - 2'(r_s3_pos.left_out) - 2'(r_s3_pos.right_out);
        if (s3_rows == 2'd0) begin
            s3_rows = 2'd1;
        end
        if (s3_cols == 2'd0) begin
            s3_cols = 2'd1;
        end
        s3_cnt = 4'(s3_rows) * 4'(s3_cols);
        unique case (s3_cnt)
            4'd2: begin
                s3_mul = RECIP_ONE;
                s3_shf = SHF_W'(1);
            end
            4'd3: begin
                s3_mul = RECIP_THREE;
                s3_shf = SHF_W'(13);
            end
            4'd4: begin
                s3_mul = RECIP_ONE;
                s3_shf = SHF_W'(2);
            end
            4'd6: begin
                s3_mul = RECIP_THREE;
                s3_shf = SHF_W'(14);
            end
            4'd9: begin
                s3_mul = RECIP_NINE;
                s3_shf = SHF_W'(16);
            end
            default: begin
                s3_mul = RECIP_ONE;
                s3_shf = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s4_free) begin
            r_s4_sum  <= s3_sum;
            r_s4_mul  <= s3_mul;
            r_s4_shf  <= s3_shf;
            r_s4_last <= r_s3_pos.last;
        end
    end

    // mean by reciprocal multiply
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s4_q[ch] = PIX_W'((PROD_W'(r_s4_sum[ch]) * PROD_W'(r_s4_mul)) >> r_s4_shf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_v4) begin
            r_out.out_red    <= s4_q[0];
            r_out.out_green  <= s4_q[1];
            r_out.out_blue   <= s4_q[2];
            r_out.frame_last <= r_s4_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !s2_free |=> r_v1 && $stable(r_s1_addr) && $stable(r_s1_fresh))
        else $error("stage 1 item changed while stalled");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WID_W'(r_col) < eff_w)
        else $error("column counter beyond image width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= row_h + ROW_W'(1))
        else $error("row counter beyond drain end");

    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_load && s0_pos.last && !i_cfg_we |=> r_col == '0 && r_row == '0)
        else $error("counters not cleared after last result");

    a_res_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_exit && r_s1_res |=> r_v2)
        else $error("result lost between stage 1 and window");

endmodule
